// ===== src/sjf_pkg.sv =====
// shared types and constants for the preemptive shortest-remaining-time scheduler
// used by sjf_ctrl, sjf_dp and preemptive_sjf_scheduler; no dependencies
package sjf_pkg;

    // sizing
    localparam int MAX_JOBS      = 32;
    localparam int BURST_WIDTH   = 16;
    localparam int SLOT_W        = $clog2(MAX_JOBS);
    localparam int CNT_W         = SLOT_W + 1;
    localparam int JOB_W         = 5;
    localparam int CFG_W         = 6;
    localparam int BURST_IN_W    = 16;
    localparam int JOB_COUNT_RST = 32;
    localparam int FIN_MAX       = 63;

    // opcodes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [BURST_IN_W-1:0] burst;
    } item_t;

    typedef struct packed {
        logic             running_valid;
        logic [JOB_W-1:0] running_job;
        logic             first_dispatch;
        logic             preempt_valid;
        logic [JOB_W-1:0] preempt_job;
        logic             finish_valid;
        logic [JOB_W-1:0] finish_job;
        logic             all_done;
        logic             rejected;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic arrive;
        logic charge;
        logic scan_start;
        logic scan_run;
        logic dispatch;
        logic idle_tick;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic opcode;
        logic cpu_busy;
        logic scan_done;
        logic found;
    } stat_t;

endpackage

// ===== src/sjf_ctrl.sv =====
// control state machine of the scheduler: sequences arrival, charge and ready-slot scan
// depends on sjf_pkg for the state, command and status types
module sjf_ctrl
    import sjf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.opcode == OP_ARRIVE)
                begin
                    cmd.arrive = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.cpu_busy)
                begin
                    cmd.charge = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.found)
                    begin
                        cmd.dispatch = 1'b1;
                    end
                    else
                    begin
                        cmd.idle_tick = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== src/sjf_dp.sv =====
// datapath of the scheduler: remaining-time memory, slot status, scan unit and result register
// depends on sjf_pkg for types and sizing
module sjf_dp
    import sjf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            item,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  cmd_t             cmd,
    output stat_t            stat,
    output logic             done,
    output result_t          result
);

    // remaining time store, no reset
    logic [BURST_WIDTH-1:0] mem [MAX_JOBS];
    logic [BURST_WIDTH-1:0] rdata_reg;

    // latched transaction
    logic                   opcode_reg;
    logic [BURST_WIDTH-1:0] burst_reg;

    // scheduler state
    logic [CFG_W-1:0]    job_count_reg;
    logic [MAX_JOBS-1:0] ready_reg,    ready_next;
    logic [MAX_JOBS-1:0] disp_reg,     disp_next;
    logic [SLOT_W-1:0]   cur_job_reg,  cur_job_next;
    logic                cpu_busy_reg, cpu_busy_next;
    logic [CNT_W-1:0]    next_slot_reg, next_slot_next;
    logic [CFG_W-1:0]    fin_cnt_reg,  fin_cnt_next;

    // scan unit
    logic [CNT_W-1:0]       scan_idx_reg;
    logic                   pend_reg;
    logic [SLOT_W-1:0]      cmp_slot_reg;
    logic [SLOT_W-1:0]      best_reg;
    logic [BURST_WIDTH-1:0] best_rem_reg;
    logic                   found_reg;

    // result
    logic    done_reg,   done_next;
    result_t result_reg, result_next;

    // arrival and charge terms
    logic [SLOT_W-1:0]      arr_slot;
    logic                   arr_rej;
    logic                   arr_pre;
    logic [SLOT_W-1:0]      chg_slot;
    logic [BURST_WIDTH-1:0] chg_old;
    logic [BURST_WIDTH-1:0] chg_new;
    logic                   chg_fin;
    logic                   scan_issue;
    logic                   cmp_take;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [BURST_WIDTH-1:0] wr_data;

    assign arr_slot = next_slot_reg[SLOT_W-1:0];
    assign arr_rej  = (next_slot_reg >= CNT_W'(MAX_JOBS))
                   || (32'(next_slot_reg) >= 32'(job_count_reg))
                   || (burst_reg == '0);
    assign arr_pre  = cpu_busy_reg && (burst_reg < rdata_reg);

    // charge either the running job or the one just picked by the scan
    assign chg_slot = cmd.dispatch ? best_reg : cur_job_reg;
    assign chg_old  = cmd.dispatch ? best_rem_reg : rdata_reg;
    assign chg_new  = (chg_old != '0) ? chg_old - BURST_WIDTH'(1) : chg_old;
    assign chg_fin  = (chg_new == '0);

    // scan issues one read per cycle and compares the read data in the next cycle
    assign scan_issue = cmd.scan_run && (scan_idx_reg < CNT_W'(MAX_JOBS));
    assign cmp_take   = pend_reg && ready_reg[cmp_slot_reg]
                     && (!found_reg || (rdata_reg < best_rem_reg));
    assign rd_addr    = scan_issue ? scan_idx_reg[SLOT_W-1:0] : cur_job_reg;

    // memory write select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = chg_slot;
        wr_data = chg_new;
        if (cmd.arrive && !arr_rej)
        begin
            wr_en   = 1'b1;
            wr_addr = arr_slot;
            wr_data = burst_reg;
        end
        else if (cmd.charge || cmd.dispatch)
        begin
            wr_en = 1'b1;
        end
    end

    // next scheduler state and result
    always_comb
    begin
        ready_next     = ready_reg;
        disp_next      = disp_reg;
        cur_job_next   = cur_job_reg;
        cpu_busy_next  = cpu_busy_reg;
        next_slot_next = next_slot_reg;
        fin_cnt_next   = fin_cnt_reg;
        done_next      = cmd.arrive || cmd.charge || cmd.dispatch || cmd.idle_tick;
        result_next    = '0;

        // arrival, possibly preempting the running job
        if (cmd.arrive)
        begin
            if (arr_rej)
            begin
                result_next.rejected = 1'b1;
            end
            else
            begin
                ready_next[arr_slot] = 1'b1;
                next_slot_next       = next_slot_reg + CNT_W'(1);
                if (arr_pre)
                begin
                    result_next.preempt_valid  = 1'b1;
                    result_next.preempt_job    = JOB_W'(cur_job_reg);
                    result_next.first_dispatch = !disp_reg[arr_slot];
                    cur_job_next               = arr_slot;
                    disp_next[arr_slot]        = 1'b1;
                end
            end
        end

        // dispatch of the scan winner
        if (cmd.dispatch)
        begin
            result_next.first_dispatch = !disp_reg[best_reg];
            disp_next[best_reg]        = 1'b1;
            cur_job_next               = best_reg;
            cpu_busy_next              = 1'b1;
        end

        // charge one unit, retire at zero
        if ((cmd.charge || cmd.dispatch) && chg_fin)
        begin
            result_next.finish_valid = 1'b1;
            result_next.finish_job   = JOB_W'(chg_slot);
            ready_next[chg_slot]     = 1'b0;
            cpu_busy_next            = 1'b0;
            if (fin_cnt_reg != CFG_W'(FIN_MAX))
            begin
                fin_cnt_next = fin_cnt_reg + CFG_W'(1);
            end
        end

        result_next.running_valid = cpu_busy_next;
        result_next.running_job   = JOB_W'(cur_job_next);
        result_next.all_done      = (fin_cnt_next >= job_count_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg <= CFG_W'(JOB_COUNT_RST);
            ready_reg     <= '0;
            disp_reg      <= '0;
            cur_job_reg   <= '0;
            cpu_busy_reg  <= 1'b0;
            next_slot_reg <= '0;
            fin_cnt_reg   <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                job_count_reg <= cfg_data;
            end
            ready_reg     <= ready_next;
            disp_reg      <= disp_next;
            cur_job_reg   <= cur_job_next;
            cpu_busy_reg  <= cpu_busy_next;
            next_slot_reg <= next_slot_next;
            fin_cnt_reg   <= fin_cnt_next;
            done_reg      <= done_next;
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                pend_reg     <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (cmp_take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opcode_reg <= item.opcode;
            burst_reg  <= BURST_WIDTH'(item.burst);
        end
        if (cmd.scan_run)
        begin
            cmp_slot_reg <= scan_idx_reg[SLOT_W-1:0];
            if (cmp_take)
            begin
                best_reg     <= cmp_slot_reg;
                best_rem_reg <= rdata_reg;
            end
        end
        result_reg <= result_next;
    end

    // remaining time memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign stat.opcode    = opcode_reg;
    assign stat.cpu_busy  = cpu_busy_reg;
    assign stat.scan_done = (scan_idx_reg == CNT_W'(MAX_JOBS)) && !pend_reg;
    assign stat.found     = found_reg;

    assign done   = done_reg;
    assign result = result_reg;

    // a running job is always a ready slot
    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cpu_busy_reg |-> ready_reg[cur_job_reg])
        else $error("running job is not marked ready");

    // preemption and finish never share a transaction
    a_pre_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(result_reg.preempt_valid && result_reg.finish_valid))
        else $error("preempt and finish in one result");

    // a refused arrival changes nothing on the cpu
    a_rej_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.rejected)
            |-> !result_reg.preempt_valid && !result_reg.first_dispatch)
        else $error("rejected arrival touched the cpu");

    // finished count never goes back
    a_fin_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fin_cnt_reg >= $past(fin_cnt_reg))
        else $error("finished count decreased");

endmodule

// ===== src/preemptive_sjf_scheduler.sv =====
// Arrival, and tick with a running job, are loaded in IDLE, run in EXEC and give a registered result;
// busy is high for 1 cycle, and a new item is accepted as soon as busy is low again.
// Tick with an idle cpu scans all MAX_JOBS slots through the single read port of the
// remaining-time memory in the SCAN state, and no new item is accepted until the scan ends.
// The result strobe done lasts one cycle and cannot be stalled.
// Reset (rst_n, async, active low) clears all slot status at once; no clearing pass.
module preemptive_sjf_scheduler
    import sjf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  item_t            item,
    output logic             busy,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    sjf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // storage and arithmetic
    sjf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule
